>>> rtl/core/plfr_pkg.sv
// ----------------------------------------------------------------------------
// plfr_pkg: shared types and constants
// Item formats, command codes and controller byte codes of the LCD frame
// refresher.
// ----------------------------------------------------------------------------
package plfr_pkg;

  typedef enum logic [2:0] {
    CMD_PIXEL    = 3'd0,
    CMD_FILL     = 3'd1,
    CMD_START    = 3'd2,
    CMD_ADVANCE  = 3'd3,
    CMD_CONTRAST = 3'd4
  } cmd_e;

  // controller byte codes
  localparam logic [7:0] BYTE_PAGE_CMD   = 8'hB0;
  localparam logic [7:0] BYTE_COL_LO     = 8'h00;
  localparam logic [7:0] BYTE_COL_HI     = 8'h10;
  localparam logic [7:0] BYTE_TRAILER    = 8'hEE;
  localparam logic [7:0] BYTE_CONTRAST   = 8'h81;
  localparam logic [7:0] CONTRAST_LIMIT  = 8'd64;
  localparam int         ROWS_PER_PAGE   = 8;
  localparam int         HEADER_BYTES    = 3;

  typedef struct packed {
    logic [2:0] command;
    logic [6:0] column;
    logic [5:0] row;
    logic [7:0] level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } out_item_t;

endpackage

>>> rtl/core/plfr_stream_if.sv
// ----------------------------------------------------------------------------
// plfr_stream_if: valid/ready stream channel
// One transfer moves one payload when valid and ready are both high.
// ----------------------------------------------------------------------------
interface plfr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/page_packed_lcd_frame_refresher.sv
// ----------------------------------------------------------------------------
// page_packed_lcd_frame_refresher
// Monochrome frame store packed as pages of column bytes, with pixel
// writes, fill, contrast commands and a byte-by-byte refresh sequencer.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Payload                          | Notes
//  --------+-----+----------------------------------+--------------------------
//  in_i    | in  | command, column, row, level      | one command per transfer
//  out_o   | out | out_byte, is_data, last          | 3-entry output queue
//
//  Steps: a pixel write reads its byte, then writes it back in ST_RMW
//  through the single frame RAM port pair; a data-byte advance waits in
//  ST_DATA for the registered RAM read; a contrast command sends its two
//  bytes, one result per cycle, from ST_IDLE and ST_CONTRAST; other
//  commands finish on their transfer. A fill is the transfer cycle, then
//  one RAM write per cycle across the store. Reset: after rst_ni the store
//  is cleared by the same sweep as a fill, with in_i.ready low.
//  Stalls: in_i.ready drops when the output queue holds two or more bytes;
//  a waiting result does not block commands while at most one is queued.
// ----------------------------------------------------------------------------
module page_packed_lcd_frame_refresher
  import plfr_pkg::*;
#(
  parameter int COLUMNS = 128,
  parameter int ROWS    = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  plfr_stream_if.sink   in_i,
  plfr_stream_if.source out_o
);

  localparam int PAGES       = (ROWS + ROWS_PER_PAGE - 1) / ROWS_PER_PAGE;
  localparam int STORE_BYTES = COLUMNS * PAGES;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int COL_W       = $clog2(COLUMNS);
  localparam int POS_W       = $clog2(COLUMNS + HEADER_BYTES);
  // rows of the last page that lie inside the frame
  localparam int LAST_ROWS   = ROWS - (PAGES - 1) * ROWS_PER_PAGE;
  localparam logic [7:0] LAST_MASK = 8'((1 << LAST_ROWS) - 1);

  typedef enum logic [4:0] {
    ST_CLEAR    = 5'b00001,  // store sweep (reset clear or fill)
    ST_IDLE     = 5'b00010,  // take a command
    ST_RMW      = 5'b00100,  // pixel write back
    ST_DATA     = 5'b01000,  // refresh data byte from RAM
    ST_CONTRAST = 5'b10000   // second byte of contrast pair
  } state_e;

  state_e state_q, state_d;

  // refresh sequencer
  logic              active_q, active_d;
  logic              trailer_q, trailer_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [POS_W-1:0]  pos_q, pos_d;

  // store sweep
  logic [COL_W-1:0]  clr_col_q, clr_col_d;
  logic [PAGE_W-1:0] clr_page_q, clr_page_d;
  logic              fill_bit_q, fill_bit_d;

  // payload held from ST_IDLE into ST_RMW or ST_CONTRAST
  logic [ADDR_W-1:0] pix_addr_q, pix_addr_d;
  logic [2:0]        pix_bit_q, pix_bit_d;
  logic              pix_val_q, pix_val_d;
  logic [7:0]        level_q, level_d;

  // frame RAM
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  // output queue
  out_item_t   queue_q [3];
  logic [1:0]  rd_ptr_q, wr_ptr_q, count_q;
  logic        push, pop;
  out_item_t   push_item;

  logic in_fire;
  cmd_e cmd;
  logic pix_in_frame;
  logic clr_last_col, clr_last_page;

  assign cmd          = cmd_e'(in_i.data.command);
  assign in_i.ready   = (state_q == ST_IDLE) && (count_q <= 2'd1);
  assign in_fire      = in_i.valid && in_i.ready;
  assign pop          = out_o.valid && out_o.ready;
  assign pix_in_frame = (int'(in_i.data.column) < COLUMNS) && (int'(in_i.data.row) < ROWS);
  assign clr_last_col  = (clr_col_q == COL_W'(COLUMNS - 1));
  assign clr_last_page = (clr_page_q == PAGE_W'(PAGES - 1));

  always_comb begin
    state_d    = state_q;
    active_d   = active_q;
    trailer_d  = trailer_q;
    page_d     = page_q;
    pos_d      = pos_q;
    clr_col_d  = clr_col_q;
    clr_page_d = clr_page_q;
    fill_bit_d = fill_bit_q;
    pix_addr_d = pix_addr_q;
    pix_bit_d  = pix_bit_q;
    pix_val_d  = pix_val_q;
    level_d    = level_q;
    ram_we     = 1'b0;
    ram_waddr  = pix_addr_q;
    ram_wdata  = ram_rdata;
    ram_raddr  = ADDR_W'(page_q) * ADDR_W'(COLUMNS)
               + ADDR_W'(pos_q - POS_W'(HEADER_BYTES));
    push       = 1'b0;
    push_item  = '{out_byte: BYTE_TRAILER, is_data: 1'b0, last: 1'b0};

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(clr_page_q) * ADDR_W'(COLUMNS) + ADDR_W'(clr_col_q);
        ram_wdata = !fill_bit_q ? 8'h00 : (clr_last_page ? LAST_MASK : 8'hFF);
        if (clr_last_col) begin
          clr_col_d = '0;
          if (clr_last_page) begin
            clr_page_d = '0;
            state_d    = ST_IDLE;
          end else begin
            clr_page_d = clr_page_q + PAGE_W'(1);
          end
        end else begin
          clr_col_d = clr_col_q + COL_W'(1);
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd)
            CMD_PIXEL: begin
              if (!active_q && pix_in_frame) begin
                pix_addr_d = ADDR_W'(in_i.data.row[5:3]) * ADDR_W'(COLUMNS)
                           + ADDR_W'(in_i.data.column);
                ram_raddr  = pix_addr_d;
                pix_bit_d  = in_i.data.row[2:0];
                pix_val_d  = in_i.data.level[0];
                state_d    = ST_RMW;
              end
            end
            CMD_FILL: begin
              if (!active_q) begin
                fill_bit_d = in_i.data.level[0];
                state_d    = ST_CLEAR;
              end
            end
            CMD_START: begin
              if (!active_q) begin
                active_d  = 1'b1;
                trailer_d = 1'b0;
                page_d    = '0;
                pos_d     = '0;
              end
            end
            CMD_ADVANCE: begin
              if (active_q) begin
                if (trailer_q) begin
                  push      = 1'b1;
                  push_item = '{out_byte: BYTE_TRAILER, is_data: 1'b0, last: 1'b1};
                  active_d  = 1'b0;
                  trailer_d = 1'b0;
                  page_d    = '0;
                  pos_d     = '0;
                end else begin
                  // header bytes go out now; data bytes wait for the RAM read
                  if (pos_q == POS_W'(0)) begin
                    push      = 1'b1;
                    push_item = '{out_byte: BYTE_PAGE_CMD | {4'h0, 4'(page_q)},
                                  is_data: 1'b0, last: 1'b0};
                  end else if (pos_q == POS_W'(1)) begin
                    push      = 1'b1;
                    push_item = '{out_byte: BYTE_COL_LO, is_data: 1'b0, last: 1'b0};
                  end else if (pos_q == POS_W'(2)) begin
                    push      = 1'b1;
                    push_item = '{out_byte: BYTE_COL_HI, is_data: 1'b0, last: 1'b0};
                  end else begin
                    state_d = ST_DATA;
                  end
                  if (pos_q == POS_W'(COLUMNS + HEADER_BYTES - 1)) begin
                    pos_d = '0;
                    if (page_q == PAGE_W'(PAGES - 1)) begin
                      page_d    = '0;
                      trailer_d = 1'b1;
                    end else begin
                      page_d = page_q + PAGE_W'(1);
                    end
                  end else begin
                    pos_d = pos_q + POS_W'(1);
                  end
                end
              end
            end
            CMD_CONTRAST: begin
              if (!active_q && (in_i.data.level < CONTRAST_LIMIT)) begin
                push      = 1'b1;
                push_item = '{out_byte: BYTE_CONTRAST, is_data: 1'b0, last: 1'b0};
                level_d   = in_i.data.level;
                state_d   = ST_CONTRAST;
              end
            end
            default: ;  // unused command codes: no effect
          endcase
        end
      end

      ST_RMW: begin
        ram_we               = 1'b1;
        ram_waddr            = pix_addr_q;
        ram_wdata            = ram_rdata;
        ram_wdata[pix_bit_q] = pix_val_q;
        state_d              = ST_IDLE;
      end

      ST_DATA: begin
        push      = 1'b1;
        push_item = '{out_byte: ram_rdata, is_data: 1'b1, last: 1'b0};
        state_d   = ST_IDLE;
      end

      ST_CONTRAST: begin
        push      = 1'b1;
        push_item = '{out_byte: level_q, is_data: 1'b0, last: 1'b1};
        state_d   = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  plfr_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      active_q   <= 1'b0;
      trailer_q  <= 1'b0;
      page_q     <= '0;
      pos_q      <= '0;
      clr_col_q  <= '0;
      clr_page_q <= '0;
      fill_bit_q <= 1'b0;
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      count_q    <= '0;
    end else begin
      state_q    <= state_d;
      active_q   <= active_d;
      trailer_q  <= trailer_d;
      page_q     <= page_d;
      pos_q      <= pos_d;
      clr_col_q  <= clr_col_d;
      clr_page_q <= clr_page_d;
      fill_bit_q <= fill_bit_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == 2'd2) ? 2'd0 : wr_ptr_q + 2'd1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == 2'd2) ? 2'd0 : rd_ptr_q + 2'd1;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    pix_addr_q <= pix_addr_d;
    pix_bit_q  <= pix_bit_d;
    pix_val_q  <= pix_val_d;
    level_q    <= level_d;
    if (push) begin
      queue_q[wr_ptr_q] <= push_item;
    end
  end

  assign out_o.valid = (count_q != 2'd0);
  assign out_o.data  = queue_q[rd_ptr_q];

  // queue never overflows: a command is taken with at most one byte queued
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (count_q <= 2'd1))
    else $error("command taken with output queue too full");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |-> (count_q <= 2'd2))
    else $error("output queue overflow");

  // frame RAM is written only by the sweep or a pixel write back
  a_ram_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR || state_q == ST_RMW))
    else $error("frame RAM written outside sweep or write back");

  // data byte follows an advance taken in the previous cycle
  a_data_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DATA) |-> $past(in_fire))
    else $error("data byte without advance");

  a_trailer_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trailer_q |-> active_q)
    else $error("trailer pending outside refresh");

endmodule

>>> rtl/core/plfr_ram.sv
// ----------------------------------------------------------------------------
// plfr_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module plfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sim/page_packed_lcd_frame_refresher_test.sv
// ----------------------------------------------------------------------------
// page_packed_lcd_frame_refresher_test: frame store and refresh sequencer test
// Drives pixel writes, fills, contrast commands and refresh steps through the
// command stream and checks every byte sent to the display controller against
// a shadow frame store and sequencer kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_packed_lcd_frame_refresher_test
  import plfr_pkg::*;
();

  localparam int COLUMNS     = 128;
  localparam int ROWS        = 64;
  localparam int PAGES       = (ROWS + ROWS_PER_PAGE - 1) / ROWS_PER_PAGE;
  localparam int PAGE_SPAN   = COLUMNS + HEADER_BYTES;
  // bytes in one whole refresh: every page plus the trailer
  localparam int SCAN_BYTES  = PAGES * PAGE_SPAN + 1;
  localparam int STORE_BYTES = COLUMNS * PAGES;

  // top of the command code space; codes above CMD_CONTRAST do nothing
  localparam logic [2:0] CMD_CODE_MAX = 3'd7;

  // A fill (and the clearing sweep after reset) walks the whole store with
  // no transfer on either side, so the quiet limit sits well above that.
  localparam int QUIET_LIMIT   = 5 * STORE_BYTES;
  localparam int SETTLE_CYCLES = STORE_BYTES + 64;
  localparam int RANDOM_ITEMS  = 1800;

  typedef struct {
    in_item_t item;
    int       gap;     // idle cycles before the item is offered
    bit       pause;   // hold until every expected byte has come out
  } queued_cmd_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  // Bench-side copies of the channel inputs, known from time zero.
  logic      cmd_valid  = 1'b0;
  in_item_t  cmd_data   = '0;
  logic      byte_ready = 1'b0;
  logic      cmd_taken  = 1'b0;
  logic      byte_taken = 1'b0;

  plfr_stream_if #(.payload_t(in_item_t))  cmd_if ();
  plfr_stream_if #(.payload_t(out_item_t)) byte_if ();

  assign cmd_if.valid  = cmd_valid;
  assign cmd_if.data   = cmd_data;
  assign byte_if.ready = byte_ready;

  page_packed_lcd_frame_refresher #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (byte_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Reset is held from time zero and released on a falling edge.
  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Shadow of the block: frame store and refresh sequencer state.
  // --------------------------------------------------------------------------
  logic [7:0]  shadow_frame [STORE_BYTES];
  logic        scan_busy   = 1'b0;
  int          scan_page   = 0;
  int          scan_pos    = 0;   // 0 page cmd, 1..2 column cmds, then data
  logic        trailer_due = 1'b0;
  out_item_t   pending_lcd_bytes [$];
  int          mismatches  = 0;

  initial begin
    foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
  end

  function automatic out_item_t lcd_byte(logic [7:0] value, logic data, logic fin);
    out_item_t b;
    b.out_byte = value;
    b.is_data  = data;
    b.last     = fin;
    return b;
  endfunction

  // Work out the bytes one accepted command causes and update the shadow.
  task automatic apply_lcd_command(in_item_t cmd);
    int         idx;
    int         rows_left;
    logic [7:0] row_bit;
    logic [7:0] fill_byte;
    logic [7:0] value;
    logic       data;
    case (cmd.command)
      CMD_PIXEL: begin
        if (!scan_busy && cmd.column < COLUMNS && cmd.row < ROWS) begin
          idx     = (cmd.row / ROWS_PER_PAGE) * COLUMNS + cmd.column;
          row_bit = 8'd1 << (cmd.row % ROWS_PER_PAGE);
          if (cmd.level[0]) shadow_frame[idx] = shadow_frame[idx] | row_bit;
          else              shadow_frame[idx] = shadow_frame[idx] & ~row_bit;
        end
      end
      CMD_FILL: begin
        if (!scan_busy) begin
          for (int p = 0; p < PAGES; p++) begin
            // rows past the frame bottom in a short last page stay clear
            rows_left = ROWS - p * ROWS_PER_PAGE;
            if (!cmd.level[0])                 fill_byte = 8'h00;
            else if (rows_left >= ROWS_PER_PAGE) fill_byte = 8'hFF;
            else                               fill_byte = 8'((1 << rows_left) - 1);
            for (int c = 0; c < COLUMNS; c++) shadow_frame[p * COLUMNS + c] = fill_byte;
          end
        end
      end
      CMD_START: begin
        if (!scan_busy) begin
          scan_busy   = 1'b1;
          scan_page   = 0;
          scan_pos    = 0;
          trailer_due = 1'b0;
        end
      end
      CMD_ADVANCE: begin
        if (scan_busy && trailer_due) begin
          pending_lcd_bytes.push_back(lcd_byte(BYTE_TRAILER, 1'b0, 1'b1));
          scan_busy   = 1'b0;
          trailer_due = 1'b0;
          scan_page   = 0;
          scan_pos    = 0;
        end else if (scan_busy) begin
          data = 1'b0;
          if (scan_pos == 0)      value = BYTE_PAGE_CMD | (8'(scan_page) & 8'h0F);
          else if (scan_pos == 1) value = BYTE_COL_LO;
          else if (scan_pos == 2) value = BYTE_COL_HI;
          else begin
            value = shadow_frame[scan_page * COLUMNS + scan_pos - HEADER_BYTES];
            data  = 1'b1;
          end
          pending_lcd_bytes.push_back(lcd_byte(value, data, 1'b0));
          scan_pos++;
          if (scan_pos >= PAGE_SPAN) begin
            scan_pos = 0;
            scan_page++;
            if (scan_page >= PAGES) begin
              scan_page   = 0;
              trailer_due = 1'b1;
            end
          end
        end
      end
      CMD_CONTRAST: begin
        if (!scan_busy && cmd.level < CONTRAST_LIMIT) begin
          pending_lcd_bytes.push_back(lcd_byte(BYTE_CONTRAST, 1'b0, 1'b0));
          pending_lcd_bytes.push_back(lcd_byte(cmd.level, 1'b0, 1'b1));
        end
      end
      default: ;  // unused codes change nothing
    endcase
  endtask

  task automatic flag_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("%0t: mismatch on %s: got %02h, expected %02h", $time, what, got, want);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled on the rising edge.
  // Predict first, so a byte leaving on the same edge still finds its entry.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      cmd_taken  <= 1'b0;
      byte_taken <= 1'b0;
    end else begin
      cmd_taken  <= cmd_valid && cmd_if.ready;
      byte_taken <= byte_if.valid && byte_ready;
      if (cmd_valid && cmd_if.ready) apply_lcd_command(cmd_if.data);
      if (byte_if.valid && byte_ready) begin
        if (pending_lcd_bytes.size() == 0) begin
          flag_mismatch("unexpected byte", byte_if.data.out_byte, 8'h00);
        end else begin
          want = pending_lcd_bytes.pop_front();
          if (byte_if.data.out_byte !== want.out_byte)
            flag_mismatch("out_byte", byte_if.data.out_byte, want.out_byte);
          if (byte_if.data.is_data !== want.is_data)
            flag_mismatch("is_data", 8'(byte_if.data.is_data), 8'(want.is_data));
          if (byte_if.data.last !== want.last)
            flag_mismatch("last", 8'(byte_if.data.last), 8'(want.last));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command driver: offers the backlog on falling edges, one item per
  // transfer, after that item's gap. A pause item also waits for the output
  // side to drain completely.
  // --------------------------------------------------------------------------
  queued_cmd_t cmd_backlog [$];
  int          hold_cycles = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      cmd_valid   <= 1'b0;
      hold_cycles = 0;
    end else if (!cmd_valid || cmd_taken) begin
      if (cmd_backlog.size() != 0 && hold_cycles >= cmd_backlog[0].gap &&
          !(cmd_backlog[0].pause && pending_lcd_bytes.size() != 0)) begin
        cmd_data  <= cmd_backlog[0].item;
        cmd_valid <= 1'b1;
        cmd_backlog.delete(0);
        hold_cycles = 0;
      end else begin
        cmd_valid <= 1'b0;
        hold_cycles++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Byte sink: after each transfer draws a random stall; now and then
  // switches into a calm stretch where it never stalls.
  // --------------------------------------------------------------------------
  int stall_left = 0;
  bit sink_calm  = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      byte_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (byte_taken) begin
        if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
        stall_left = sink_calm ? 0 : $urandom_range(0, 5);
      end
      if (stall_left > 0) begin
        byte_ready <= 1'b0;
        stall_left--;
      end else begin
        byte_ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without a transfer on either side means a hang.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((cmd_valid && cmd_if.ready) || (byte_if.valid && byte_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus builder. It tracks on its own whether a refresh would be running
  // so the random part can run whole refreshes to their trailer.
  // --------------------------------------------------------------------------
  int scan_steps_left = 0;   // advances still needed by the running refresh
  bit sender_calm     = 1'b0;
  bit pause_next      = 1'b0;

  task automatic queue_command(logic [2:0] code, logic [6:0] col, logic [5:0] row,
                               logic [7:0] lvl);
    queued_cmd_t q;
    q.item.command = code;
    q.item.column  = col;
    q.item.row     = row;
    q.item.level   = lvl;
    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
    q.gap   = sender_calm ? 0 : $urandom_range(0, 5);
    q.pause = pause_next;
    pause_next = 1'b0;
    cmd_backlog.push_back(q);
    if (scan_steps_left == 0) begin
      if (code == CMD_START) scan_steps_left = SCAN_BYTES;
    end else if (code == CMD_ADVANCE) begin
      scan_steps_left--;
    end
  endtask

  initial begin : stimulus
    int pick;
    // -- directed part --
    queue_command(CMD_ADVANCE, 7'd0, 6'd0, 8'h00);          // advance while idle
    queue_command(CMD_CONTRAST, 7'd0, 6'd0, 8'd0);
    queue_command(CMD_CONTRAST, 7'd127, 6'd63, CONTRAST_LIMIT - 8'd1);
    queue_command(CMD_CONTRAST, 7'd0, 6'd0, CONTRAST_LIMIT); // too high, dropped
    queue_command(CMD_CONTRAST, 7'd0, 6'd0, 8'hFF);
    for (int c = int'(CMD_CONTRAST) + 1; c <= int'(CMD_CODE_MAX); c++)
      queue_command(3'(c), 7'd127, 6'd63, 8'hFF);             // unused codes
    queue_command(CMD_FILL, 7'd0, 6'd0, 8'h01);              // all pixels on
    // clear the four corners, set one pixel back, using only bit 0 of level
    queue_command(CMD_PIXEL, 7'd0, 6'd0, 8'hFE);
    queue_command(CMD_PIXEL, 7'd127, 6'd63, 8'h00);
    queue_command(CMD_PIXEL, 7'd127, 6'd0, 8'h00);
    queue_command(CMD_PIXEL, 7'd0, 6'd63, 8'hFE);
    queue_command(CMD_PIXEL, 7'd127, 6'd63, 8'hFF);
    // start only once the contrast bytes have all come out
    pause_next = 1'b1;
    queue_command(CMD_START, 7'd0, 6'd0, 8'h00);
    repeat (4) queue_command(CMD_ADVANCE, 7'd0, 6'd0, 8'h00);
    // everything but advance is ignored while a refresh runs
    queue_command(CMD_PIXEL, 7'd1, 6'd1, 8'h00);
    queue_command(CMD_FILL, 7'd0, 6'd0, 8'h00);
    queue_command(CMD_CONTRAST, 7'd0, 6'd0, 8'd5);
    queue_command(CMD_START, 7'd0, 6'd0, 8'h00);
    queue_command(CMD_ADVANCE, 7'd0, 6'd0, 8'h00);

    // -- random part: fill the backlog up to the item budget --
    while (cmd_backlog.size() < RANDOM_ITEMS) begin
      if ($urandom_range(0, 149) == 0) pause_next = 1'b1;
      pick = $urandom_range(0, 99);
      if (scan_steps_left != 0) begin
        // mostly walk the refresh on; sprinkle in anything else
        if (pick < 88) queue_command(CMD_ADVANCE, 7'($urandom), 6'($urandom), 8'($urandom));
        else           queue_command(3'($urandom), 7'($urandom), 6'($urandom), 8'($urandom));
      end else if (pick < 66) begin
        queue_command(CMD_PIXEL, 7'($urandom), 6'($urandom), 8'($urandom));
      end else if (pick < 78) begin
        if ($urandom_range(0, 3) == 0)
          queue_command(CMD_CONTRAST, 7'($urandom), 6'($urandom),
                        8'($urandom_range(int'(CONTRAST_LIMIT), 255)));
        else
          queue_command(CMD_CONTRAST, 7'($urandom), 6'($urandom),
                        8'($urandom_range(0, int'(CONTRAST_LIMIT) - 1)));
      end else if (pick < 80) begin
        queue_command(CMD_FILL, 7'($urandom), 6'($urandom), 8'($urandom));
      end else if (pick < 84) begin
        queue_command(CMD_START, 7'($urandom), 6'($urandom), 8'($urandom));
      end else if (pick < 92) begin
        queue_command(CMD_ADVANCE, 7'($urandom), 6'($urandom), 8'($urandom));
      end else begin
        queue_command(3'($urandom_range(int'(CMD_CONTRAST) + 1, int'(CMD_CODE_MAX))),
                      7'($urandom), 6'($urandom), 8'($urandom));
      end
    end

    // -- wind down --
    while (cmd_backlog.size() != 0 || cmd_valid) @(posedge clk_i);
    while (pending_lcd_bytes.size() != 0) @(posedge clk_i);
    // a trailing fill may still be sweeping; any stray byte is caught here
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else                 $display("CHECKS FAILED");
    $finish;
  end

endmodule
